// ===== rtl/fpps_pkg.sv =====
`timescale 1ns / 1ps
package fpps_pkg;

	localparam int SAMPLE_BITS       = 16;
	localparam int GUARD_BITS        = 16;
	localparam int CORDIC_W          = SAMPLE_BITS + GUARD_BITS + 8;
	localparam int GAIN_W            = 16;
	localparam int INV_GAIN_Q15      = 19899;
	localparam int FIFO_DEPTH_DEF    = 4096;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam logic [2:0] SET_COUNT_RESET = 3'd2;
	localparam logic [2:0] SET_COUNT_PAIR  = 3'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [CORDIC_W-1:0]    cword_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_INDEX = 2'd1,
		STATUS_SIZE  = 2'd2,
		STATUS_SETS  = 2'd3
	} status_t;

	typedef struct packed {
		logic        pixel_set;
		logic [15:0] image_number;
		sample_t     real_part;
		sample_t     imag_part;
		logic        image_end;
	} pixel_t;

	typedef struct packed {
		sample_t     out_real;
		sample_t     out_imag;
		logic [15:0] out_image_number;
		logic        out_end;
		status_t     status;
	} result_t;

	typedef struct packed {
		logic [15:0] image_number;
		sample_t     real_part;
		sample_t     imag_part;
		logic        image_end;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic queued_set;
	} store_status_t;

	typedef struct packed {
		cword_t x;
		cword_t y;
	} vec_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_PAIR,
		TS_CALC
	} top_state_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_VEC,
		CS_MEAN,
		CS_BACK,
		CS_SCALE,
		CS_ROUND,
		CS_DONE
	} cordic_state_t;

	localparam logic signed [GAIN_W-1:0] INV_GAIN = GAIN_W'(INV_GAIN_Q15);

	// one micro-rotation, shifts are arithmetic (floor)
	function automatic vec_t cordic_step(vec_t v, logic [5:0] sh, logic d);
		vec_t   r;
		cword_t dx;
		cword_t dy;
		dx = v.y >>> sh;
		dy = v.x >>> sh;
		if (d) begin
			r.x = v.x + dx;
			r.y = v.y - dy;
		end else begin
			r.x = v.x - dx;
			r.y = v.y + dy;
		end
		return r;
	endfunction

	function automatic sample_t saturate(cword_t v);
		cword_t hi;
		cword_t lo;
		hi = CORDIC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - CORDIC_W'(1);
		if (v > hi) return SAMPLE_BITS'(hi);
		else if (v < lo) return SAMPLE_BITS'(lo);
		else return SAMPLE_BITS'(v);
	endfunction

	function automatic cword_t widen(sample_t s);
		cword_t w;
		w = CORDIC_W'(s);
		return w <<< GUARD_BITS;
	endfunction

endpackage

// ===== rtl/flow_phase_pair_subtract.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// pixel     in         valid / stall      fpps_pkg::pixel_t
// result    out        valid / stall      fpps_pkg::result_t
// cfg       in         valid / ready      set_count, 3 bits
//
// passthrough, too-many-sets, queued and dropped pixels: one pixel per cycle unless the result side stalls
// a paired pixel stalls the pixel side until its result is loaded; a mismatched pair
// leaves from the pair state, a combined pair waits for the single iterative cordic unit
// reset empties the pairing queue and sets set_count to two; no clearing pass
// a held result stalls the pixel side once the output register is full
module flow_phase_pair_subtract #(
	parameter int FIFO_DEPTH    = fpps_pkg::FIFO_DEPTH_DEF,
	parameter int CORDIC_STAGES = fpps_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  fpps_pkg::pixel_t  pixel,
	output logic              result_valid,
	input  logic              result_stall,
	output fpps_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_data
);
	import fpps_pkg::*;

	top_state_t    state_q, state_d;
	logic [2:0]    set_count_q;
	pixel_t        inc_q;
	result_t       out_q;
	logic          out_valid_q;

	store_status_t st;
	entry_t        head;
	entry_t        wentry;
	logic          accept, out_free, pair_mode, pop, push;
	logic          load_direct, load_pair, load_cordic, mismatch;
	entry_t        a_ent, b_ent;
	logic          c_start, c_valid;
	sample_t       c_re, c_im;
	result_t       direct_res, pair_res, cordic_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) set_count_q <= SET_COUNT_RESET;
		else if (cfg_valid) set_count_q <= cfg_data;
	end

	// handshake
	assign out_free    = !out_valid_q || !result_stall;
	assign pixel_stall = (state_q != TS_IDLE) || !out_free;
	assign accept      = pixel_valid && !pixel_stall;
	assign pair_mode   = (set_count_q == SET_COUNT_PAIR);

	// a pixel meets a queued partner of the other set, or waits its turn, or is dropped when the queue is full
	assign pop  = accept && pair_mode && !st.empty && (st.queued_set != pixel.pixel_set);
	assign push = accept && pair_mode && !pop && !st.full;

	assign wentry.image_number = pixel.image_number;
	assign wentry.real_part    = pixel.real_part;
	assign wentry.imag_part    = pixel.imag_part;
	assign wentry.image_end    = pixel.image_end;

	fpps_store #(.DEPTH(FIFO_DEPTH)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_set (pixel.pixel_set),
		.wdata    (wentry),
		.pop      (pop),
		.rdata    (head),
		.status   (st)
	);

	always_ff @(posedge clk) begin
		if (accept) inc_q <= pixel;
	end

	// set 0 pixel is a, set 1 pixel is b
	always_comb begin
		a_ent.image_number = inc_q.image_number;
		a_ent.real_part    = inc_q.real_part;
		a_ent.imag_part    = inc_q.imag_part;
		a_ent.image_end    = inc_q.image_end;
		b_ent = head;
		if (inc_q.pixel_set) begin
			b_ent = a_ent;
			a_ent = head;
		end
	end

	assign mismatch = (a_ent.image_number != b_ent.image_number) ||
	                  (a_ent.image_end != b_ent.image_end);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: if (pop) state_d = TS_PAIR;
			TS_PAIR: begin
				if (!mismatch) state_d = TS_CALC;
				else if (out_free) state_d = TS_IDLE;
			end
			TS_CALC: if (c_valid && out_free) state_d = TS_IDLE;
			default: state_d = TS_IDLE;
		endcase
	end

	always_comb begin
		load_direct = accept && !pair_mode;
		load_pair   = (state_q == TS_PAIR) && mismatch && out_free;
		load_cordic = (state_q == TS_CALC) && c_valid && out_free;
		c_start     = (state_q == TS_PAIR) && !mismatch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= TS_IDLE;
		else state_q <= state_d;
	end

	fpps_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (c_start),
		.a_re      (a_ent.real_part),
		.a_im      (a_ent.imag_part),
		.b_re      (b_ent.real_part),
		.b_im      (b_ent.imag_part),
		.ack       (load_cordic),
		.res_valid (c_valid),
		.res_re    (c_re),
		.res_im    (c_im)
	);

	// results: passthrough or too many sets, pair mismatch, combined pixel
	always_comb begin
		if (set_count_q > SET_COUNT_PAIR) begin
			direct_res = '0;
			direct_res.status = STATUS_SETS;
		end else begin
			direct_res.out_real         = pixel.real_part;
			direct_res.out_imag         = pixel.imag_part;
			direct_res.out_image_number = pixel.image_number;
			direct_res.out_end          = pixel.image_end;
			direct_res.status           = STATUS_OK;
		end
		pair_res.out_real         = '0;
		pair_res.out_imag         = '0;
		pair_res.out_image_number = b_ent.image_number;
		pair_res.out_end          = b_ent.image_end;
		pair_res.status = (a_ent.image_number != b_ent.image_number) ? STATUS_INDEX
		                                                             : STATUS_SIZE;
		cordic_res.out_real         = c_re;
		cordic_res.out_imag         = c_im;
		cordic_res.out_image_number = b_ent.image_number;
		cordic_res.out_end          = b_ent.image_end;
		cordic_res.status           = STATUS_OK;
	end

	always_ff @(posedge clk) begin
		priority if (load_direct) out_q <= direct_res;
		else if (load_pair) out_q <= pair_res;
		else if (load_cordic) out_q <= cordic_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_direct || load_pair || load_cordic) out_valid_q <= 1'b1;
		else if (!result_stall) out_valid_q <= 1'b0;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== rtl/fpps_store.sv =====
`timescale 1ns / 1ps
module fpps_store #(
	parameter int DEPTH = fpps_pkg::FIFO_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    push_set,
	input  fpps_pkg::entry_t        wdata,
	input  logic                    pop,
	output fpps_pkg::entry_t        rdata,
	output fpps_pkg::store_status_t status
);
	import fpps_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            set_q;
	entry_t          rdata_q;

	// only one set waits at any time, so one queue serves both
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wdata;
		if (pop) rdata_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			set_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
				if (count_q == '0) set_q <= push_set;
			end
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	assign rdata             = rdata_q;
	assign status.empty      = (count_q == '0);
	assign status.full       = (count_q == CW'(DEPTH));
	assign status.queued_set = set_q;

endmodule

// ===== rtl/fpps_cordic.sv =====
`timescale 1ns / 1ps
module fpps_cordic #(
	parameter int STAGES = fpps_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fpps_pkg::sample_t a_re,
	input  fpps_pkg::sample_t a_im,
	input  fpps_pkg::sample_t b_re,
	input  fpps_pkg::sample_t b_im,
	input  logic              ack,
	output logic              res_valid,
	output fpps_pkg::sample_t res_re,
	output fpps_pkg::sample_t res_im
);
	import fpps_pkg::*;

	localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

	cordic_state_t state_q, state_d;
	logic [SW-1:0] step_q;
	logic          last_step;
	vec_t          a_q, b_q, c_q, m_q;
	logic          fc_q;
	cword_t        px_q, py_q;
	sample_t       re_q, im_q;

	logic          da, db, dc;
	cword_t        ax0, ay0, bx0, by0, sum;
	logic signed [CORDIC_W+GAIN_W-1:0] prod_m, prod_x, prod_y;
	cword_t        mx_f, my_f, rx, ry;

	assign last_step = (step_q == SW'(STAGES - 1));
	assign da = !a_q.y[CORDIC_W-1];
	assign db = !b_q.y[CORDIC_W-1];
	assign dc = !c_q.y[CORDIC_W-1];
	assign ax0 = widen(a_re);
	assign ay0 = widen(a_im);
	assign bx0 = widen(b_re);
	assign by0 = widen(b_im);
	assign sum = a_q.x + b_q.x;
	assign prod_m = sum * INV_GAIN;
	assign mx_f = fc_q ? -m_q.x : m_q.x;
	assign my_f = fc_q ? -m_q.y : m_q.y;
	assign prod_x = mx_f * INV_GAIN;
	assign prod_y = my_f * INV_GAIN;
	assign rx = (px_q + CORDIC_W'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
	assign ry = (py_q + CORDIC_W'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:  if (start) state_d = CS_VEC;
			CS_VEC:   if (last_step) state_d = CS_MEAN;
			CS_MEAN:  state_d = CS_BACK;
			CS_BACK:  if (last_step) state_d = CS_SCALE;
			CS_SCALE: state_d = CS_ROUND;
			CS_ROUND: state_d = CS_DONE;
			CS_DONE:  if (ack) state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		res_valid = (state_q == CS_DONE);
		res_re    = re_q;
		res_im    = im_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == CS_VEC || state_q == CS_BACK) && !last_step)
				step_q <= step_q + SW'(1);
			else
				step_q <= '0;
		end
	end

	// datapath: a and b vectored, c rotated by a's directions in lockstep;
	// then c vectored while the mean is rotated back in lockstep
	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_IDLE: begin
				if (start) begin
					a_q.x <= a_re[SAMPLE_BITS-1] ? -ax0 : ax0;
					a_q.y <= a_re[SAMPLE_BITS-1] ? -ay0 : ay0;
					b_q.x <= b_re[SAMPLE_BITS-1] ? -bx0 : bx0;
					b_q.y <= b_re[SAMPLE_BITS-1] ? -by0 : by0;
					c_q.x <= a_re[SAMPLE_BITS-1] ? -bx0 : bx0;
					c_q.y <= a_re[SAMPLE_BITS-1] ? -by0 : by0;
				end
			end
			CS_VEC: begin
				a_q <= cordic_step(a_q, 6'(step_q), da);
				b_q <= cordic_step(b_q, 6'(step_q), db);
				c_q <= cordic_step(c_q, 6'(step_q), da);
			end
			CS_MEAN: begin
				m_q.x <= CORDIC_W'(prod_m >>> 16);
				m_q.y <= '0;
				fc_q  <= c_q.x[CORDIC_W-1];
				c_q.x <= c_q.x[CORDIC_W-1] ? -c_q.x : c_q.x;
				c_q.y <= c_q.x[CORDIC_W-1] ? -c_q.y : c_q.y;
			end
			CS_BACK: begin
				c_q <= cordic_step(c_q, 6'(step_q), dc);
				m_q <= cordic_step(m_q, 6'(step_q), !dc);
			end
			CS_SCALE: begin
				px_q <= CORDIC_W'(prod_x >>> 15);
				py_q <= CORDIC_W'(prod_y >>> 15);
			end
			CS_ROUND: begin
				re_q <= saturate(rx);
				im_q <= saturate(ry);
			end
			CS_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/flow_phase_pair_subtract_tb.sv =====
`timescale 1ns / 1ps
module flow_phase_pair_subtract_tb;
	import fpps_pkg::*;

	localparam int QUEUE_DEPTH = 4096;
	localparam int STAGES      = 16;
	localparam int WATCH_LIMIT = 6000;
	localparam int DRAIN_WAIT  = 2 * STAGES + 30;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES    = 20;
	localparam int PIXELS_PER_PHASE = 80;

	// pairing predictor and result store
	class phase_pair_scoreboard;
		logic [2:0] set_count = SET_COUNT_RESET;
		pixel_t     set0_q[$];
		pixel_t     set1_q[$];
		result_t    expected_q[$];
		int         n_errors = 0;

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			n_errors++;
		endtask

		function int pending();
			return expected_q.size();
		endfunction

		// floor shift on signed values
		function automatic void rotate_step(ref longint x, ref longint y, input int i,
				input bit d);
			longint dx;
			longint dy;
			dx = x;
			dy = y;
			dx = y >>> i;
			dy = x >>> i;
			if (d) begin
				x = x + dx;
				y = y - dy;
			end else begin
				x = x - dx;
				y = y + dy;
			end
		endfunction

		function automatic void vectorise(ref longint x, ref longint y,
				output bit [STAGES-1:0] dirs, output bit flip);
			bit d;
			flip = (x < 0);
			if (flip) begin
				x = -x;
				y = -y;
			end
			for (int i = 0; i < STAGES; i++) begin
				d = (y >= 0);
				rotate_step(x, y, i, d);
				dirs[i] = d;
			end
		endfunction

		function automatic logic [15:0] to_sample(longint v);
			v = (v * INV_GAIN_Q15) >>> 15;
			v = (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		// mean magnitude, phase of b less phase of a
		function automatic void phase_difference(pixel_t a, pixel_t b, inout result_t r);
			longint ax, ay, bx, by, cx, cy, m, ry;
			bit [STAGES-1:0] da, db, dc;
			bit fa, fb, fc;
			ax = longint'(a.real_part) <<< GUARD_BITS;
			ay = longint'(a.imag_part) <<< GUARD_BITS;
			bx = longint'(b.real_part) <<< GUARD_BITS;
			by = longint'(b.imag_part) <<< GUARD_BITS;
			cx = bx;
			cy = by;
			vectorise(ax, ay, da, fa);
			vectorise(bx, by, db, fb);
			m = ((ax + bx) * INV_GAIN_Q15) >>> 16;
			if (fa) begin
				cx = -cx;
				cy = -cy;
			end
			for (int i = 0; i < STAGES; i++)
				rotate_step(cx, cy, i, da[i]);
			vectorise(cx, cy, dc, fc);
			ry = 0;
			for (int i = 0; i < STAGES; i++)
				rotate_step(m, ry, i, !dc[i]);
			if (fc) begin
				m = -m;
				ry = -ry;
			end
			r.out_real = to_sample(m);
			r.out_imag = to_sample(ry);
		endfunction

		function void note_pixel(pixel_t p);
			result_t r;
			pixel_t  a;
			pixel_t  b;
			r = '0;
			if (set_count > SET_COUNT_PAIR) begin
				r.status = STATUS_SETS;
				expected_q.push_back(r);
				return;
			end
			if (set_count < SET_COUNT_PAIR) begin
				r.out_real = p.real_part;
				r.out_imag = p.imag_part;
				r.out_image_number = p.image_number;
				r.out_end = p.image_end;
				r.status = STATUS_OK;
				expected_q.push_back(r);
				return;
			end
			// a full queue drops the pixel when its partner is empty
			if (p.pixel_set == 1'b0) begin
				if (set0_q.size() >= QUEUE_DEPTH) return;
				set0_q.push_back(p);
			end else begin
				if (set1_q.size() >= QUEUE_DEPTH) return;
				set1_q.push_back(p);
			end
			if (set0_q.size() == 0 || set1_q.size() == 0) return;
			a = set0_q.pop_front();
			b = set1_q.pop_front();
			r.out_image_number = b.image_number;
			r.out_end = b.image_end;
			if (a.image_number != b.image_number) begin
				r.status = STATUS_INDEX;
			end else if (a.image_end != b.image_end) begin
				r.status = STATUS_SIZE;
			end else begin
				phase_difference(a, b, r);
				r.status = STATUS_OK;
			end
			expected_q.push_back(r);
		endfunction

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("unexpected result transaction at %0t", $realtime);
				n_errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_real !== want.out_real)
				report("out_real", got.out_real, want.out_real);
			if (got.out_imag !== want.out_imag)
				report("out_imag", got.out_imag, want.out_imag);
			if (got.out_image_number !== want.out_image_number)
				report("out_image_number", got.out_image_number, want.out_image_number);
			if (got.out_end !== want.out_end)
				report("out_end", got.out_end, want.out_end);
			if (got.status !== want.status)
				report("status", got.status, want.status);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       pixel_valid;
	logic       pixel_stall;
	pixel_t     pixel;
	logic       result_valid;
	logic       result_stall;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_data;

	phase_pair_scoreboard sb = new();
	bit calm      = 0;     // no idling in the last part of the run
	bit hold_req  = 0;     // asks the receiver for one long hold-off
	int quiet_cycles = 0;

	flow_phase_pair_subtract DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// every accepted result transaction goes against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// watchdog: cycles in which no transaction moves on any channel
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		result_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 0;
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				result_stall <= 1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				result_stall <= 0;
			end else if (!calm && $urandom_range(0, 40) == 0) begin
				// a stretch with no stalling
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	task automatic send_pixel(input pixel_t p);
		if (!calm && $urandom_range(0, 9) == 0) begin
			pixel_valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		pixel <= p;
		pixel_valid <= 1;
		do @(posedge clk); while (pixel_stall);
		sb.note_pixel(p);
	endtask

	task automatic make_and_send(input bit s, input logic [15:0] num, input logic [15:0] re,
			input logic [15:0] im, input bit e);
		pixel_t p;
		p.pixel_set = s;
		p.image_number = num;
		p.real_part = re;
		p.imag_part = im;
		p.image_end = e;
		send_pixel(p);
	endtask

	// wait until every expected result has come, then let the cordic settle
	task automatic drain();
		pixel_valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_set_count(input logic [2:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_count = v;
	endtask

	// one image of pixel pairs in random order, with an occasional broken pair
	task automatic send_image(input int n_pix);
		logic [15:0] num;
		pixel_t a;
		pixel_t b;
		num = 16'($urandom);
		for (int k = 0; k < n_pix; k++) begin
			a.pixel_set = 0;
			a.image_number = num;
			a.real_part = 16'($urandom);
			a.imag_part = 16'($urandom);
			a.image_end = (k == n_pix - 1);
			b = a;
			b.pixel_set = 1;
			b.real_part = 16'($urandom);
			b.imag_part = 16'($urandom);
			case ($urandom_range(0, 19))
				0: b.image_number = 16'($urandom);
				1: b.image_end = !a.image_end;
				2: begin
					a.image_number = 16'($urandom);
					a.image_end = 1'($urandom);
				end
				3: begin
					a.real_part = 16'sh8000;
					b.imag_part = 16'sh7fff;
				end
				default: ;
			endcase
			if ($urandom_range(0, 1)) begin
				send_pixel(a);
				send_pixel(b);
			end else begin
				send_pixel(b);
				send_pixel(a);
			end
		end
	endtask

	initial begin
		logic [2:0] mode;
		int sent;
		int n_pix;
		bit rested;
		rested = 0;
		arst_n = 0;
		pixel_valid = 0;
		pixel = '0;
		cfg_valid = 0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes in subtract mode, several set-0 pixels waiting
		make_and_send(0, 16'h0000, 16'h7fff, 16'h7fff, 0);
		make_and_send(0, 16'hffff, 16'h8000, 16'h8000, 1);
		make_and_send(0, 16'h1234, 16'h0000, 16'h0000, 0);
		make_and_send(1, 16'h0000, 16'h8000, 16'h7fff, 0);
		make_and_send(1, 16'hffff, 16'h7fff, 16'h8000, 1);
		make_and_send(1, 16'h1234, 16'h0000, 16'h0000, 0);
		// index mismatch and size mismatch
		make_and_send(1, 16'h00ff, 16'h4000, 16'hc000, 0);
		make_and_send(0, 16'hff00, 16'h4000, 16'hc000, 0);
		make_and_send(0, 16'h5555, 16'h2000, 16'h1000, 0);
		make_and_send(1, 16'h5555, 16'h2000, 16'h1000, 1);
		// negative real part on both sides
		make_and_send(0, 16'haaaa, 16'h8001, 16'h0001, 1);
		make_and_send(1, 16'haaaa, 16'h9000, 16'hffff, 1);
		// one set waits while the mode changes
		make_and_send(0, 16'h0042, 16'h1111, 16'h2222, 0);
		write_set_count(3'd1);
		make_and_send(0, 16'hffff, 16'h8000, 16'h7fff, 1);
		make_and_send(1, 16'h0000, 16'h7fff, 16'h8000, 0);
		write_set_count(3'd0);
		make_and_send(1, 16'h8001, 16'h1357, 16'hfedc, 1);
		write_set_count(3'd3);
		make_and_send(0, 16'h0001, 16'h7fff, 16'h7fff, 1);
		write_set_count(3'd7);
		make_and_send(1, 16'hffff, 16'h8000, 16'h8000, 0);
		write_set_count(3'd2);
		make_and_send(1, 16'h0042, 16'h3333, 16'h4444, 0);

		// random phases, mostly subtract mode
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == N_PHASES - 3) calm = 1;
			case ($urandom_range(0, 9))
				0: mode = 3'd1;
				1: mode = 3'd0;
				2: mode = 3'($urandom_range(3, 7));
				default: mode = SET_COUNT_PAIR;
			endcase
			if (ph == 2) mode = SET_COUNT_PAIR;
			if (mode != sb.set_count) write_set_count(mode);
			if (ph == 2) hold_req = 1;   // block fills up and stalls its input
			sent = 0;
			while (sent < PIXELS_PER_PHASE) begin
				if (mode == SET_COUNT_PAIR) begin
					n_pix = $urandom_range(1, 12);
					send_image(n_pix);
					sent += 2 * n_pix;
				end else begin
					make_and_send(1'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 1'($urandom));
					sent += 1;
				end
				if (ph == 5 && !rested && sent >= 40) begin
					// sender rests until the block has caught up
					rested = 1;
					pixel_valid <= 0;
					while (sb.pending() != 0) @(posedge clk);
				end
			end
		end

		drain();
		if (sb.pending() != 0) begin
			$display("results still expected: %0d", sb.pending());
			sb.n_errors++;
		end
		if (sb.n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== flow_phase_pair_subtract.f =====
rtl/fpps_pkg.sv
rtl/fpps_store.sv
rtl/fpps_cordic.sv
rtl/flow_phase_pair_subtract.sv
tb/flow_phase_pair_subtract_tb.sv
